>>> sv/rggc_pkg.sv
// Shared types, constants and the elaboration-time gamma table builder
// for the RGB gain and gamma correction core. No dependencies.
package rggc_pkg;

  // Pixel and gain widths.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned GAIN_W = 7;
  localparam int unsigned PROD_W = CHAN_W + GAIN_W;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [1:0] REG_NORMAL_WHITE = 2'd0;
  localparam logic [1:0] REG_NORMAL_COLOR = 2'd1;
  localparam logic [1:0] REG_PANEL_GREY   = 2'd2;
  localparam logic [1:0] REG_PANEL_COLOR  = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(100);

  // Floor division by 100 as a reciprocal multiply: exact for products below 43690.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUOT_W      = 9;

  // Output ceiling and gamma curve setup.
  localparam logic [CHAN_W-1:0] CLAMP_MAX = CHAN_W'(250);
  localparam int unsigned GAMMA_MILLI_DEF = 2200;
  localparam logic [63:0] GAMMA_DEN = 64'd1000;
  localparam int unsigned FRAC_BITS = 31;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  // The four gain registers as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] normal_white;
    logic [GAIN_W-1:0] normal_color;
    logic [GAIN_W-1:0] panel_grey;
    logic [GAIN_W-1:0] panel_color;
  } gains_t;

  // Scaled channel products between the two pipeline stages.
  typedef struct packed {
    logic [PROD_W-1:0] red;
    logic [PROD_W-1:0] green;
    logic [PROD_W-1:0] blue;
  } prod_t;

  typedef logic [255:0][CHAN_W-1:0] gamma_tab_t;

  // Integer square root, two bits per step.
  function automatic logic [63:0] isqrt64(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bitv > n) begin
        bitv = bitv >> 2;
      end
    end
    for (int s = 0; s < 32; s++) begin
      if (bitv != 64'd0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Restoring shift-subtract quotient, used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // log2(255/i) in Q31 for 1 <= i <= 255, by repeated squaring.
  function automatic logic [63:0] log2_ratio(logic [63:0] i);
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] frac;
    k    = 64'd0;
    frac = 64'd0;
    for (int s = 0; s < 8; s++) begin
      if ((i << (k + 64'd1)) <= 64'd255) begin
        k = k + 64'd1;
      end
    end
    m = udiv64(64'd255 << FRAC_BITS, i << k);
    for (int b = FRAC_BITS - 1; b >= 0; b--) begin
      m = (m * m) >> FRAC_BITS;
      if (m >= (ONE_Q << 1)) begin
        m       = m >> 1;
        frac[b] = 1'b1;
      end
    end
    return (k << FRAC_BITS) | frac;
  endfunction

  // Gamma curve round(255*(i/255)^gamma) in fixed point, already held to
  // the output ceiling so the datapath needs no clamp after the lookup.
  function automatic gamma_tab_t build_gamma(int unsigned gamma_milli);
    gamma_tab_t  tab;
    logic [63:0] root [FRAC_BITS+1];
    logic [63:0] e;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] y;
    logic [63:0] v;
    logic [63:0] gm;
    gm      = 64'(gamma_milli);
    root[0] = ONE_Q >> 1;
    for (int j = 1; j <= FRAC_BITS; j++) begin
      root[j] = isqrt64(root[j-1] << FRAC_BITS);
    end
    tab[0] = (gm == 64'd0) ? CLAMP_MAX : CHAN_W'(0);
    for (int i = 1; i < 256; i++) begin
      e   = (log2_ratio(64'(i)) * gm + 64'd500) / GAMMA_DEN;
      q   = e >> FRAC_BITS;
      f   = e & (ONE_Q - 64'd1);
      acc = ONE_Q;
      for (int j = 1; j <= FRAC_BITS; j++) begin
        if (f[FRAC_BITS-j]) begin
          acc = (acc * root[j]) >> FRAC_BITS;
        end
      end
      y = 64'd255 * acc;
      y = (q >= 64'd63) ? 64'd0 : (y >> q);
      v = (y + (ONE_Q >> 1)) >> FRAC_BITS;
      if (v > 64'(CLAMP_MAX)) begin
        v = 64'(CLAMP_MAX);
      end
      tab[i] = v[CHAN_W-1:0];
    end
    return tab;
  endfunction

endpackage

>>> sv/rggc_regs.sv
// Gain register file behind the APB-style configuration port.
// Depends on rggc_pkg for widths, register indexes and gains_t.
module rggc_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rggc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rggc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rggc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output rggc_pkg::gains_t               gains
);
  import rggc_pkg::*;

  gains_t     gains_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign gains      = gains_r;

  // Register writes land in the access cycle; only the low seven bits are kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.normal_white <= GAIN_RESET;
      gains_r.normal_color <= GAIN_RESET;
      gains_r.panel_grey   <= GAIN_RESET;
      gains_r.panel_color  <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NORMAL_WHITE: gains_r.normal_white <= cfg_pwdata[GAIN_W-1:0];
        REG_NORMAL_COLOR: gains_r.normal_color <= cfg_pwdata[GAIN_W-1:0];
        REG_PANEL_GREY:   gains_r.panel_grey   <= cfg_pwdata[GAIN_W-1:0];
        REG_PANEL_COLOR:  gains_r.panel_color  <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_NORMAL_WHITE: cfg_prdata[GAIN_W-1:0] = gains_r.normal_white;
      REG_NORMAL_COLOR: cfg_prdata[GAIN_W-1:0] = gains_r.normal_color;
      REG_PANEL_GREY:   cfg_prdata[GAIN_W-1:0] = gains_r.panel_grey;
      REG_PANEL_COLOR:  cfg_prdata[GAIN_W-1:0] = gains_r.panel_color;
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

>>> sv/rggc_scale.sv
// First pipeline stage: grey detection, gain selection and the per-channel
// gain multiply into the product register. Depends on rggc_pkg.
module rggc_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [rggc_pkg::CHAN_W-1:0] in_red_in,
  input  logic [rggc_pkg::CHAN_W-1:0] in_green_in,
  input  logic [rggc_pkg::CHAN_W-1:0] in_blue_in,
  input  rggc_pkg::gains_t            gains,
  input  logic                        dn_ready,
  output logic                        prod_valid,
  output rggc_pkg::prod_t             prod
);
  import rggc_pkg::*;

  logic              prod_valid_r;
  logic              prod_valid_nxt;
  prod_t             prod_r;
  logic              grey;
  logic              accept;
  logic [GAIN_W-1:0] gain;

  // Grey pixels take the white gain of the selected target.
  assign grey = (in_red_in == in_green_in) && (in_green_in == in_blue_in);

  always_comb begin
    unique case ({in_action, grey})
      2'b00:   gain = gains.normal_color;
      2'b01:   gain = gains.normal_white;
      2'b10:   gain = gains.panel_color;
      default: gain = gains.panel_grey;
    endcase
  end

  // The stage takes a beat whenever its register is empty or draining.
  assign in_stall = prod_valid_r & ~dn_ready;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    prod_valid_nxt = prod_valid_r;
    if (accept) begin
      prod_valid_nxt = 1'b1;
    end else if (dn_ready) begin
      prod_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
    end
  end

  // Channel times gain percent; the divide by 100 follows in the next stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r.red   <= PROD_W'(in_red_in)   * PROD_W'(gain);
      prod_r.green <= PROD_W'(in_green_in) * PROD_W'(gain);
      prod_r.blue  <= PROD_W'(in_blue_in)  * PROD_W'(gain);
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule

>>> sv/rggc_gamma.sv
// Second pipeline stage: divide by 100, saturate, gamma table lookup and the
// result register. Depends on rggc_pkg for the table builder and types.
module rggc_gamma #(
  parameter int unsigned GAMMA_MILLI = rggc_pkg::GAMMA_MILLI_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        prod_valid,
  input  rggc_pkg::prod_t             prod,
  output logic                        up_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rggc_pkg::CHAN_W-1:0] out_red_out,
  output logic [rggc_pkg::CHAN_W-1:0] out_green_out,
  output logic [rggc_pkg::CHAN_W-1:0] out_blue_out
);
  import rggc_pkg::*;

  // Gamma curve, clamped to the output ceiling, fixed at elaboration.
  localparam gamma_tab_t GammaTab = build_gamma(GAMMA_MILLI);

  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;
  logic [CHAN_W-1:0] idx_red;
  logic [CHAN_W-1:0] idx_green;
  logic [CHAN_W-1:0] idx_blue;
  logic              take;

  // Floor of product/100, held at 255 when the gain pushes past full scale.
  function automatic logic [CHAN_W-1:0] scale_index(logic [PROD_W-1:0] p);
    logic [MUL_W-1:0]  full;
    logic [QUOT_W-1:0] quo;
    full = MUL_W'(p) * MUL_W'(RECIP_100);
    quo  = full[RECIP_SHIFT +: QUOT_W];
    return quo[QUOT_W-1] ? {CHAN_W{1'b1}} : quo[CHAN_W-1:0];
  endfunction

  assign idx_red   = scale_index(prod.red);
  assign idx_green = scale_index(prod.green);
  assign idx_blue  = scale_index(prod.blue);

  // The result register frees up when empty or when its beat is taken.
  assign up_ready = ~out_valid_r | ~out_stall;
  assign take     = prod_valid & up_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      red_r   <= GammaTab[idx_red];
      green_r <= GammaTab[idx_green];
      blue_r  <= GammaTab[idx_blue];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

endmodule

>>> sv/rgb_gain_gamma_correction_core.sv
// Top level of the RGB gain and gamma correction core.
// Depends on rggc_pkg, rggc_regs, rggc_scale and rggc_gamma.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    action, red_in, green_in, blue_in
//   out_     output     out_valid / out_stall  red_out, green_out, blue_out
//   cfg_     input      APB psel/penable       four 7-bit gain registers at 4*i
//
// Each pixel passes two register stages: the gain multiply fills the product
// register at the input beat, and divide-by-100 and the gamma table then fill
// the result register from the product register. One pixel is accepted every
// cycle while in_stall is low, that is, while the pipeline is not backed up.
// A stall on the output holds the result register and backs up through the
// product register to in_stall. Reset clears both valid flags and sets
// every gain to 100; the gamma table is a constant and needs no fill.
module rgb_gain_gamma_correction_core #(
  parameter int unsigned GAMMA_MILLI = rggc_pkg::GAMMA_MILLI_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [rggc_pkg::CHAN_W-1:0]     in_red_in,
  input  logic [rggc_pkg::CHAN_W-1:0]     in_green_in,
  input  logic [rggc_pkg::CHAN_W-1:0]     in_blue_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rggc_pkg::CHAN_W-1:0]     out_red_out,
  output logic [rggc_pkg::CHAN_W-1:0]     out_green_out,
  output logic [rggc_pkg::CHAN_W-1:0]     out_blue_out,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rggc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rggc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rggc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import rggc_pkg::*;

  gains_t gains;
  prod_t  prod;
  logic   prod_valid;
  logic   dn_ready;

  // Gain registers.
  rggc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .gains       (gains)
  );

  // Gain selection and multiply.
  rggc_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .gains       (gains),
    .dn_ready    (dn_ready),
    .prod_valid  (prod_valid),
    .prod        (prod)
  );

  // Divide, gamma lookup and result register.
  rggc_gamma #(
    .GAMMA_MILLI (GAMMA_MILLI)
  ) u_gamma (
    .clk           (clk),
    .rst_n         (rst_n),
    .prod_valid    (prod_valid),
    .prod          (prod),
    .up_ready      (dn_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

endmodule

>>> tb/rgb_gain_gamma_correction_core_test.sv
// Self-checking testbench for rgb_gain_gamma_correction_core: a directed table of pixels,
// then random pixels under several gain settings, with random gaps on both channels.
// Depends on rggc_pkg and the core; it builds its own gamma curve to predict every pixel.
module rgb_gain_gamma_correction_core_test;
  import rggc_pkg::*;

  localparam int unsigned CURVE_FRAC   = 31;
  localparam int unsigned CURVE_GAMMA  = GAMMA_MILLI_DEF;
  localparam int unsigned OUT_CEIL     = 250;
  localparam int unsigned PHASE_COUNT  = 10;
  localparam int unsigned PHASE_PIXELS = 173;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct {
    bit     action;
    pixel_t px;
    bit     typed;
    pixel_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = 1'b0;
  logic [CHAN_W-1:0]     in_red_in = '0;
  logic [CHAN_W-1:0]     in_green_in = '0;
  logic [CHAN_W-1:0]     in_blue_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAN_W-1:0]     out_red_out;
  logic [CHAN_W-1:0]     out_green_out;
  logic [CHAN_W-1:0]     out_blue_out;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Gamma curve before the output ceiling, and the gain registers as the core holds them.
  bit [7:0]          curve_rom [256];
  logic [GAIN_W-1:0] gain_reg [4];

  pixel_t    pixel_due [$];
  stim_row_t dir_rows [$];
  int        mismatch_cnt = 0;
  bit        in_burst = 1'b0;
  bit        out_burst = 1'b0;
  int        stall_left = 0;
  int        idle_cycles = 0;

  rgb_gain_gamma_correction_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, two bits per step.
  function automatic bit [63:0] int_sqrt(bit [63:0] n_in);
    bit [63:0] n;
    bit [63:0] res;
    bit [63:0] probe;
    n     = n_in;
    res   = 64'd0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 64'd0) begin
      if (n >= res + probe) begin
        n   = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Fixed-point log2(255/i) with 31 fraction bits, by repeated squaring of the mantissa.
  function automatic bit [63:0] log2_of_ratio(int unsigned i);
    bit [63:0] k;
    bit [63:0] m;
    bit [63:0] frac;
    k    = 64'd0;
    frac = 64'd0;
    while ((64'(i) << (k + 64'd1)) <= 64'd255) k = k + 64'd1;
    m = (64'd255 << CURVE_FRAC) / (64'(i) << k);
    for (int b = CURVE_FRAC - 1; b >= 0; b--) begin
      m = (m * m) >> CURVE_FRAC;
      if (m >= (64'd1 << (CURVE_FRAC + 1))) begin
        m       = m >> 1;
        frac[b] = 1'b1;
      end
    end
    return (k << CURVE_FRAC) | frac;
  endfunction

  // Fill the curve with round(255*(i/255)^gamma), computed as 255 * 2^-(gamma*log2(255/i)).
  function automatic void fill_curve();
    bit [63:0] root [CURVE_FRAC+1];
    bit [63:0] one_q;
    bit [63:0] e;
    bit [63:0] q;
    bit [63:0] f;
    bit [63:0] acc;
    bit [63:0] y;
    bit [63:0] v;
    one_q   = 64'd1 << CURVE_FRAC;
    root[0] = one_q >> 1;
    for (int j = 1; j <= CURVE_FRAC; j++) root[j] = int_sqrt(root[j-1] << CURVE_FRAC);
    curve_rom[0] = (CURVE_GAMMA == 0) ? 8'd255 : 8'd0;
    for (int i = 1; i < 256; i++) begin
      e   = (log2_of_ratio(i) * 64'(CURVE_GAMMA) + 64'd500) / 64'd1000;
      q   = e >> CURVE_FRAC;
      f   = e & (one_q - 64'd1);
      acc = one_q;
      for (int j = 1; j <= CURVE_FRAC; j++) begin
        if (f[CURVE_FRAC-j]) acc = (acc * root[j]) >> CURVE_FRAC;
      end
      y = 64'd255 * acc;
      y = (q >= 64'd63) ? 64'd0 : (y >> q);
      v = (y + (one_q >> 1)) >> CURVE_FRAC;
      curve_rom[i] = (v > 64'd255) ? 8'd255 : v[7:0];
    end
  endfunction

  // One channel: percent gain, truncated, saturated to the table range, looked up, then held to the output ceiling.
  function automatic logic [CHAN_W-1:0] corrected_channel(logic [CHAN_W-1:0] value,
                                                          logic [GAIN_W-1:0] gain);
    int unsigned scaled;
    bit [7:0]    level;
    scaled = (int'(value) * int'(gain)) / 100;
    if (scaled > 255) scaled = 255;
    level = curve_rom[scaled[7:0]];
    return (level > OUT_CEIL) ? CHAN_W'(OUT_CEIL) : level;
  endfunction

  // Grey pixels take the white gain of the chosen target, all others the color gain.
  function automatic pixel_t corrected_pixel(bit action, pixel_t px);
    bit                grey;
    logic [GAIN_W-1:0] gain;
    pixel_t            res;
    grey = (px.red == px.green) && (px.green == px.blue);
    if (action) begin
      gain = grey ? gain_reg[REG_PANEL_GREY] : gain_reg[REG_PANEL_COLOR];
    end else begin
      gain = grey ? gain_reg[REG_NORMAL_WHITE] : gain_reg[REG_NORMAL_COLOR];
    end
    res.red   = corrected_channel(px.red, gain);
    res.green = corrected_channel(px.green, gain);
    res.blue  = corrected_channel(px.blue, gain);
    return res;
  endfunction

  function automatic void add_row(bit action, int r, int g, int b,
                                  bit typed, int wr, int wg, int wb);
    stim_row_t row;
    row.action     = action;
    row.px.red     = CHAN_W'(r);
    row.px.green   = CHAN_W'(g);
    row.px.blue    = CHAN_W'(b);
    row.typed      = typed;
    row.want.red   = CHAN_W'(wr);
    row.want.green = CHAN_W'(wg);
    row.want.blue  = CHAN_W'(wb);
    dir_rows.push_back(row);
  endfunction

  // Random pixel: plenty of grey and near-grey pixels, channel extremes, and noise.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     mode;
    int     level;
    mode = $urandom_range(0, 9);
    px   = pixel_t'($urandom());
    if (mode <= 2) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (mode == 3) begin
      level    = $urandom_range(0, 3);
      px.red   = (level == 0) ? 8'd0 : (level == 1) ? 8'd1 : (level == 2) ? 8'd254 : 8'd255;
      px.green = px.red;
      px.blue  = px.red;
    end else if (mode == 4) begin
      px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end else if (mode == 5) begin
      px.green = px.red;
      px.blue  = px.red ^ 8'd1;
    end
    return px;
  endfunction

  // Send one pixel beat after a random gap; the expectation is queued when it is accepted.
  task automatic send_pixel(bit action, pixel_t px, bit typed, pixel_t want);
    int     gap;
    pixel_t due;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= action;
    in_red_in   <= px.red;
    in_green_in <= px.green;
    in_blue_in  <= px.blue;
    due = typed ? want : corrected_pixel(action, px);
    do @(posedge clk); while (!(in_valid && !in_stall));
    pixel_due.push_back(due);
  endtask

  // Drop the input valid and let every queued pixel come out before touching the gains.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. Upper data bits may be noise.
  task automatic write_gain(logic [1:0] idx, logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom_range(0, 1) ? CFG_DATA_W'($urandom()) : '0;
    data[GAIN_W-1:0] = gain;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    gain_reg[idx] = data[GAIN_W-1:0];
  endtask

  function automatic logic [GAIN_W-1:0] random_gain();
    if ($urandom_range(0, 4) == 0) return GAIN_W'($urandom_range(101, 127));
    return GAIN_W'($urandom_range(0, 100));
  endfunction

  // Main sequence: reset, directed table, then phases of random pixels per gain setting.
  initial begin
    pixel_t px;
    pixel_t none;
    logic [GAIN_W-1:0] g0;
    logic [GAIN_W-1:0] g1;
    logic [GAIN_W-1:0] g2;
    logic [GAIN_W-1:0] g3;
    none = '0;
    fill_curve();
    for (int i = 0; i < 4; i++) gain_reg[i] = GAIN_RESET;

    // At reset gains, black maps to 0 and full scale to the output ceiling.
    add_row(0,   0,   0,   0, 1,   0,   0,   0);
    add_row(0, 255, 255, 255, 1, 250, 250, 250);
    add_row(1,   0,   0,   0, 1,   0,   0,   0);
    add_row(1, 255, 255, 255, 1, 250, 250, 250);
    add_row(0, 255,   0, 255, 1, 250,   0, 250);
    add_row(1,   0, 255,   0, 1,   0, 250,   0);
    add_row(0,   1,   1,   1, 0, 0, 0, 0);
    add_row(1, 128, 128, 128, 0, 0, 0, 0);
    add_row(1, 127, 128, 129, 0, 0, 0, 0);
    add_row(0, 254, 255, 254, 0, 0, 0, 0);
    add_row(1,  85, 170,  85, 0, 0, 0, 0);
    add_row(0, 200, 100,  50, 0, 0, 0, 0);
    add_row(1,  10,  20,  30, 0, 0, 0, 0);
    add_row(0, 254, 254, 254, 0, 0, 0, 0);
    add_row(1,   1,   0,   0, 0, 0, 0, 0);
    add_row(0,   0,   0,   1, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].action, dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    // Fixed extremes first (zero gain, full 7-bit gain past saturation, mixed), then random.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          g0 = '0; g1 = '0; g2 = '0; g3 = '0;
        end
        1: begin
          g0 = '1; g1 = '1; g2 = '1; g3 = '1;
        end
        2: begin
          g0 = 7'd100; g1 = 7'd0; g2 = 7'd127; g3 = 7'd1;
        end
        3: begin
          g0 = 7'd1; g1 = 7'd100; g2 = 7'd0; g3 = 7'd127;
        end
        default: begin
          g0 = random_gain(); g1 = random_gain(); g2 = random_gain(); g3 = random_gain();
        end
      endcase
      drain_pixels();
      write_gain(REG_NORMAL_WHITE, g0);
      write_gain(REG_NORMAL_COLOR, g1);
      write_gain(REG_PANEL_GREY, g2);
      write_gain(REG_PANEL_COLOR, g3);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        px = random_pixel();
        send_pixel(1'($urandom_range(0, 1)), px, 1'b0, none);
      end
    end

    // Let the pipeline empty, then keep the clock running to catch any stray beat.
    in_valid <= 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pixel_due.size() == 0) begin
      $display("[rgb_gain_gamma_correction_core] OK");
    end else begin
      $display("[rgb_gain_gamma_correction_core] ERROR");
    end
    $finish;
  end

  // Result side: check each accepted beat against the oldest expectation, then draw a stall.
  always @(posedge clk) begin : result_check
    pixel_t got;
    pixel_t due;
    int     wait_cycles;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.red   = out_red_out;
        got.green = out_green_out;
        got.blue  = out_blue_out;
        if (pixel_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("unexpected result beat: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
          end
        end else begin
          due = pixel_due.pop_front();
          if (got !== due) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       due.red, due.green, due.blue, got.red, got.green, got.blue);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        wait_cycles = out_burst ? 0 : $urandom_range(0, 8);
        if (wait_cycles > 0) begin
          out_stall  <= 1'b1;
          stall_left <= wait_cycles;
        end
      end else if (out_stall) begin
        if (stall_left <= 1) out_stall <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!out_burst && $urandom_range(0, 15) == 0) begin
        // Occasionally stall while nothing is offered, so the stall meets the pipeline filling.
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 8);
      end
    end
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[rgb_gain_gamma_correction_core] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
